FILE: rtl/acsv_pkg.sv
// ----------------------------------------------------------------------------
// Archive container validator package
// Phase codes, failure codes, block tags and the status bundle handed from
// the byte parser to the result stage.
// ----------------------------------------------------------------------------
package acsv_pkg;

   // parse phases
   localparam logic [2:0] PH_HDR  = 3'd0;
   localparam logic [2:0] PH_FAT  = 3'd1;
   localparam logic [2:0] PH_NAME = 3'd2;
   localparam logic [2:0] PH_FILE = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_ERR  = 3'd5;

   // failure codes
   localparam logic [3:0] FAIL_NONE      = 4'd0;
   localparam logic [3:0] FAIL_TAG       = 4'd1;
   localparam logic [3:0] FAIL_BYTEORDER = 4'd2;
   localparam logic [3:0] FAIL_VERSION   = 4'd3;
   localparam logic [3:0] FAIL_SIZE      = 4'd4;
   localparam logic [3:0] FAIL_HDRLEN    = 4'd5;
   localparam logic [3:0] FAIL_BLOCKS    = 4'd6;
   localparam logic [3:0] FAIL_FAT_TAG   = 4'd7;
   localparam logic [3:0] FAIL_FAT_SIZE  = 4'd8;
   localparam logic [3:0] FAIL_FNT_TAG   = 4'd9;
   localparam logic [3:0] FAIL_FNT_SIZE  = 4'd10;
   localparam logic [3:0] FAIL_GMIF_TAG  = 4'd11;
   localparam logic [3:0] FAIL_GMIF_SIZE = 4'd12;
   localparam logic [3:0] FAIL_ENTRY     = 4'd13;
   localparam logic [3:0] FAIL_TRUNC     = 4'd14;

   // little-endian tags as seen in the shift word
   localparam logic [31:0] TAG_NARC = 32'h4352414E;
   localparam logic [31:0] TAG_BTAF = 32'h46415442;
   localparam logic [31:0] TAG_BTNF = 32'h464E5442;
   localparam logic [31:0] TAG_GMIF = 32'h46494D47;

   localparam logic [15:0] BYTE_ORDER  = 16'hFFFE;
   localparam logic [15:0] VERSION     = 16'h0100;
   localparam logic [15:0] HEADER_LEN  = 16'd16;
   localparam logic [15:0] BLOCK_COUNT = 16'd3;

   localparam logic [31:0] FAT_START    = 32'd16;
   localparam logic [31:0] FAT_MIN      = 32'd12;
   localparam logic [31:0] BLK_MIN      = 32'd8;
   localparam logic [31:0] SIZE_KNOWN   = 32'd12;
   localparam logic [31:0] FAT_FIT_MIN  = 32'd24;

   // archive state after the current beat, as seen by the result stage
   typedef struct packed {
      logic [3:0]  first_error;
      logic        length_over;
      logic [31:0] byte_count;
      logic [31:0] declared_size;
      logic [15:0] member_count;
      logic [31:0] data_offset;
      logic        in_data;
   } status_type;

endpackage

FILE: rtl/acsv_parser.sv
// ----------------------------------------------------------------------------
// Archive byte parser
// Shifts in one byte per beat, walks the header and the three chained blocks
// and records the first failure. Clears itself after the last beat.
// ----------------------------------------------------------------------------
module acsv_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     beat_valid,
   input  logic [7:0]               beat_data,
   input  logic                     beat_last,
   output acsv_pkg::status_type     status
);

   logic [31:0] pos_ff, pos_in;
   logic        over_ff, over_in;
   logic [2:0]  phase_ff, phase_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] decl_ff, decl_in;
   logic [31:0] fat_size_ff, fat_size_in;
   logic [15:0] count_ff, count_in;
   logic [31:0] entry_start_ff, entry_start_in;
   logic [31:0] max_end_ff, max_end_in;
   logic [31:0] block_start_ff, block_start_in;
   logic [31:0] block_size_ff, block_size_in;
   logic [3:0]  err_ff, err_in;

   logic [3:0]  fail_c;
   logic [31:0] rel;
   logic [31:0] entry_rel;
   logic [28:0] fat_slots;
   logic [31:0] room_fat;
   logic [31:0] room_blk;

   always_comb begin
      pos_in         = pos_ff;
      over_in        = over_ff;
      phase_in       = phase_ff;
      decl_in        = decl_ff;
      fat_size_in    = fat_size_ff;
      count_in       = count_ff;
      entry_start_in = entry_start_ff;
      max_end_in     = max_end_ff;
      block_start_in = block_start_ff;
      block_size_in  = block_size_ff;
      err_in         = err_ff;
      fail_c         = acsv_pkg::FAIL_NONE;

      word_in = {beat_data, word_ff[31:8]};
      if (pos_ff == '1) begin
         over_in = 1'b1;
      end else begin
         pos_in = pos_ff + 32'd1;
      end

      rel       = pos_ff - block_start_ff;
      entry_rel = rel - 32'd12;
      fat_slots = 29'((fat_size_ff - acsv_pkg::FAT_MIN) >> 3);
      // room behind the allocation table; header checks keep decl >= 24
      room_fat  = decl_ff - acsv_pkg::FAT_START - fat_size_ff;
      room_blk  = decl_ff - block_start_ff;

      if (!over_in) begin
         unique case (phase_ff)
            acsv_pkg::PH_HDR: begin
               unique case (pos_ff)
                  32'd3: begin
                     if (word_in != acsv_pkg::TAG_NARC) fail_c = acsv_pkg::FAIL_TAG;
                  end
                  32'd5: begin
                     if (word_in[31:16] != acsv_pkg::BYTE_ORDER)
                        fail_c = acsv_pkg::FAIL_BYTEORDER;
                  end
                  32'd7: begin
                     if (word_in[31:16] != acsv_pkg::VERSION)
                        fail_c = acsv_pkg::FAIL_VERSION;
                  end
                  32'd11: begin
                     decl_in = word_in;
                  end
                  32'd13: begin
                     if (word_in[31:16] != acsv_pkg::HEADER_LEN)
                        fail_c = acsv_pkg::FAIL_HDRLEN;
                  end
                  32'd15: begin
                     if (word_in[31:16] != acsv_pkg::BLOCK_COUNT) begin
                        fail_c = acsv_pkg::FAIL_BLOCKS;
                     end else if (decl_ff < acsv_pkg::FAT_FIT_MIN) begin
                        fail_c = acsv_pkg::FAIL_FAT_TAG;
                     end else begin
                        phase_in       = acsv_pkg::PH_FAT;
                        block_start_in = acsv_pkg::FAT_START;
                     end
                  end
                  default: ;
               endcase
            end
            acsv_pkg::PH_FAT: begin
               if (rel == 32'd3) begin
                  if (word_in != acsv_pkg::TAG_BTAF) fail_c = acsv_pkg::FAIL_FAT_TAG;
               end else if (rel == 32'd7) begin
                  fat_size_in = word_in;
                  if (word_in < acsv_pkg::FAT_MIN ||
                      word_in > decl_ff - acsv_pkg::FAT_START)
                     fail_c = acsv_pkg::FAIL_FAT_SIZE;
               end else if (rel == 32'd9) begin
                  count_in = word_in[31:16];
                  if ({13'd0, word_in[31:16]} > fat_slots)
                     fail_c = acsv_pkg::FAIL_FAT_SIZE;
                  else if (room_fat < acsv_pkg::BLK_MIN)
                     fail_c = acsv_pkg::FAIL_FNT_TAG;
               end else if (rel >= 32'd12 && entry_rel[31:3] < {13'd0, count_ff}) begin
                  if (entry_rel[2:0] == 3'd3) begin
                     entry_start_in = word_in;
                  end else if (entry_rel[2:0] == 3'd7) begin
                     if (entry_start_ff > word_in)
                        fail_c = acsv_pkg::FAIL_ENTRY;
                     else if (word_in > max_end_ff)
                        max_end_in = word_in;
                  end
               end
               if (fail_c == acsv_pkg::FAIL_NONE && rel >= 32'd11 &&
                   rel == fat_size_ff - 32'd1) begin
                  phase_in       = acsv_pkg::PH_NAME;
                  block_start_in = acsv_pkg::FAT_START + fat_size_ff;
               end
            end
            acsv_pkg::PH_NAME: begin
               if (rel == 32'd3) begin
                  if (word_in != acsv_pkg::TAG_BTNF) fail_c = acsv_pkg::FAIL_FNT_TAG;
               end else if (rel == 32'd7) begin
                  block_size_in = word_in;
                  if (word_in < acsv_pkg::BLK_MIN || word_in > room_blk)
                     fail_c = acsv_pkg::FAIL_FNT_SIZE;
                  else if (room_blk - word_in < acsv_pkg::BLK_MIN)
                     fail_c = acsv_pkg::FAIL_GMIF_TAG;
               end
               if (fail_c == acsv_pkg::FAIL_NONE && rel >= 32'd7 &&
                   rel == block_size_in - 32'd1) begin
                  phase_in       = acsv_pkg::PH_FILE;
                  block_start_in = block_start_ff + block_size_in;
               end
            end
            acsv_pkg::PH_FILE: begin
               if (rel == 32'd3) begin
                  if (word_in != acsv_pkg::TAG_GMIF) fail_c = acsv_pkg::FAIL_GMIF_TAG;
               end else if (rel == 32'd7) begin
                  block_size_in = word_in;
                  // must end exactly at the declared size
                  if (word_in < acsv_pkg::BLK_MIN || word_in != room_blk)
                     fail_c = acsv_pkg::FAIL_GMIF_SIZE;
                  else if (max_end_ff > word_in - acsv_pkg::BLK_MIN)
                     fail_c = acsv_pkg::FAIL_ENTRY;
                  else
                     phase_in = acsv_pkg::PH_DATA;
               end
            end
            default: ;
         endcase
      end

      if (fail_c != acsv_pkg::FAIL_NONE) begin
         err_in   = fail_c;
         phase_in = acsv_pkg::PH_ERR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (beat_valid && beat_last)) begin
         pos_ff         <= '0;
         over_ff        <= 1'b0;
         phase_ff       <= acsv_pkg::PH_HDR;
         word_ff        <= '0;
         decl_ff        <= '0;
         fat_size_ff    <= '0;
         count_ff       <= '0;
         entry_start_ff <= '0;
         max_end_ff     <= '0;
         block_start_ff <= '0;
         block_size_ff  <= '0;
         err_ff         <= acsv_pkg::FAIL_NONE;
      end else if (beat_valid) begin
         pos_ff         <= pos_in;
         over_ff        <= over_in;
         phase_ff       <= phase_in;
         word_ff        <= word_in;
         decl_ff        <= decl_in;
         fat_size_ff    <= fat_size_in;
         count_ff       <= count_in;
         entry_start_ff <= entry_start_in;
         max_end_ff     <= max_end_in;
         block_start_ff <= block_start_in;
         block_size_ff  <= block_size_in;
         err_ff         <= err_in;
      end
   end

   assign status.first_error   = err_in;
   assign status.length_over   = over_in;
   assign status.byte_count    = pos_in;
   assign status.declared_size = decl_in;
   assign status.member_count  = count_in;
   assign status.data_offset   = block_start_in + 32'd8;
   assign status.in_data       = (phase_in == acsv_pkg::PH_DATA);

   a_err_phase: assert property (@(posedge clock) disable iff (reset)
      (err_ff != acsv_pkg::FAIL_NONE) == (phase_ff == acsv_pkg::PH_ERR))
      else $error("error code and error phase disagree");

   a_fat_start: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == acsv_pkg::PH_FAT) |-> (block_start_ff == acsv_pkg::FAT_START))
      else $error("allocation table not at offset 16");

   a_over_sat: assert property (@(posedge clock) disable iff (reset)
      over_ff |-> (pos_ff == '1))
      else $error("length overflow without saturated count");

endmodule

FILE: rtl/acsv_result.sv
// ----------------------------------------------------------------------------
// Archive verdict stage
// Resolves the final failure code on the last beat and holds the verdict in
// the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module acsv_result (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  acsv_pkg::status_type status,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [87:0]          rsp_tdata
);

   logic        valid_ff;
   logic        ok_ff, ok_in;
   logic [3:0]  code_ff, code_in;
   logic [15:0] members_ff, members_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] bytes_ff;
   logic        size_known;
   logic        size_bad;

   always_comb begin
      code_in    = status.first_error;
      size_known = status.length_over || (status.byte_count >= acsv_pkg::SIZE_KNOWN);
      size_bad   = status.length_over || (status.declared_size != status.byte_count);
      // a wrong declared size outranks anything found after the size field
      if (status.first_error == acsv_pkg::FAIL_NONE ||
          status.first_error > acsv_pkg::FAIL_VERSION) begin
         if (size_known && size_bad)
            code_in = acsv_pkg::FAIL_SIZE;
         else if (status.first_error == acsv_pkg::FAIL_NONE && !status.in_data)
            code_in = acsv_pkg::FAIL_TRUNC;
      end
      ok_in      = (code_in == acsv_pkg::FAIL_NONE);
      members_in = ok_in ? status.member_count : '0;
      offset_in  = ok_in ? status.data_offset : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ok_ff      <= ok_in;
         code_ff    <= code_in;
         members_ff <= members_in;
         offset_ff  <= offset_in;
         bytes_ff   <= status.byte_count;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'd0, bytes_ff, offset_ff, members_ff, code_ff, ok_ff};

   a_ok_code: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (ok_ff == (code_ff == acsv_pkg::FAIL_NONE)))
      else $error("pass flag and failure code disagree");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !ok_ff) |-> (members_ff == '0 && offset_ff == '0))
      else $error("failed archive reports layout fields");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("verdict not presented after last beat");

endmodule

FILE: rtl/archive_container_stream_validator.sv
// ----------------------------------------------------------------------------
// Archive container stream validator
// Checks the header and block chain of an archive streamed one byte a beat.
// ----------------------------------------------------------------------------
// Input channel: one archive byte per beat on req_tdata, req_tlast on the
// final byte. Multi-byte fields are little-endian.
// Output channel: one verdict beat per archive, issued for the beat carrying
// req_tlast: pass flag, first failure code, member count, file data offset
// and total byte count.
// Throughput: one byte per cycle when not stalled; a byte's checks are a
// 32-bit shift and a handful of compares and subtracts resolved in its cycle.
// Latency: the verdict appears on the cycle after the last byte is taken.
// The parser state clears itself on the last byte, so the next archive may
// start on the very next cycle.
// Stall: while a verdict waits and rsp_tready is low, req_tready is low and
// no byte is taken; bytes flow again once the verdict is accepted.
// Reset: synchronous; clears the parser to the header phase and empties the
// verdict register.
// ----------------------------------------------------------------------------
module archive_container_stream_validator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata    // [0] archive_ok, [4:1] fail_code,
                                    // [20:5] member_total,
                                    // [52:21] file_data_offset,
                                    // [84:53] archive_bytes, [87:85] zero
);

   acsv_pkg::status_type status;
   logic                 beat_take;

   assign req_tready = !rsp_tvalid || rsp_tready;
   assign beat_take  = req_tvalid && req_tready;

   acsv_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_take),
      .beat_data  (req_tdata),
      .beat_last  (req_tlast),
      .status     (status)
   );

   acsv_result u_result (
      .clock      (clock),
      .reset      (reset),
      .load       (beat_take && req_tlast),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: tb/sv/archive_container_stream_validator_tb.sv
// ----------------------------------------------------------------------------
// Archive container stream validator testbench
// Streams archives one byte a beat: a directed set with one corruption of
// each kind, then random archives, 45% well formed with random content,
// the rest corrupted, cut short, extended or pure noise. A byte-level parser
// model predicts the verdict for each tlast beat; verdicts are checked field
// by field in order. Both sides stall at random outside one quiet window.
// ----------------------------------------------------------------------------
module archive_container_stream_validator_tb;

   localparam int STALL_LIMIT = 2000;
   localparam int QUIET_FROM  = 800;
   localparam int QUIET_TO    = 1800;
   localparam int BYTE_TARGET = 1950;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } byte_beat_type;

   typedef struct {
      logic        ok;
      logic [3:0]  code;
      logic [15:0] members;
      logic [31:0] offset;
      logic [31:0] count;
   } verdict_type;

   typedef enum int {
      MUT_NONE, MUT_TAG, MUT_BOM, MUT_VER, MUT_SIZE, MUT_HDRLEN, MUT_BLOCKS,
      MUT_FAT_TAG, MUT_FAT_SIZE, MUT_FNT_TAG, MUT_FNT_SIZE, MUT_GMIF_TAG,
      MUT_GMIF_SIZE, MUT_ENTRY_ORDER, MUT_ENTRY_END, MUT_TRUNC, MUT_EXTEND,
      MUT_POKE, MUT_NOISE
   } mutation_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;

   byte_beat_type pending_q[$];
   byte_beat_type next_beat;
   verdict_type   verdict_q[$];
   verdict_type   want;
   int            mismatches = 0;
   int            stall_cycles = 0;
   int            cycle_n = 0;
   bit            quiet;
   bit            hold_off;

   // parser model state
   logic [31:0] pos_q, shift_q, decl_q, fat_sz_q, ent_start_q, max_end_q;
   logic [31:0] blk_start_q, blk_sz_q;
   logic [15:0] members_q;
   logic [2:0]  phase_q;
   logic [3:0]  err_q;
   logic        over_q;

   archive_container_stream_validator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------- parser model ----------------

   function automatic void clear_parser();
      pos_q = '0; shift_q = '0; decl_q = '0; fat_sz_q = '0; ent_start_q = '0;
      max_end_q = '0; blk_start_q = '0; blk_sz_q = '0; members_q = '0;
      phase_q = acsv_pkg::PH_HDR; err_q = acsv_pkg::FAIL_NONE; over_q = 1'b0;
   endfunction

   function automatic void note_fail(input logic [3:0] code);
      if (err_q == acsv_pkg::FAIL_NONE) err_q = code;
      phase_q = acsv_pkg::PH_ERR;
   endfunction

   // bytes left between offset and the declared end
   function automatic logic [63:0] room_left(input logic [63:0] offset);
      return (offset > {32'd0, decl_q}) ? 64'd0 : {32'd0, decl_q} - offset;
   endfunction

   function automatic void parse_header(input logic [31:0] pos);
      case (pos)
         32'd3: if (shift_q != acsv_pkg::TAG_NARC) note_fail(acsv_pkg::FAIL_TAG);
         32'd5: if (shift_q[31:16] != acsv_pkg::BYTE_ORDER)
            note_fail(acsv_pkg::FAIL_BYTEORDER);
         32'd7: if (shift_q[31:16] != acsv_pkg::VERSION)
            note_fail(acsv_pkg::FAIL_VERSION);
         32'd11: decl_q = shift_q;
         32'd13: if (shift_q[31:16] != acsv_pkg::HEADER_LEN)
            note_fail(acsv_pkg::FAIL_HDRLEN);
         32'd15: begin
            if (shift_q[31:16] != acsv_pkg::BLOCK_COUNT) note_fail(acsv_pkg::FAIL_BLOCKS);
            else if (room_left(64'd16) < 64'd8) note_fail(acsv_pkg::FAIL_FAT_TAG);
            else begin
               phase_q = acsv_pkg::PH_FAT;
               blk_start_q = 32'd16;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void parse_fat(input logic [31:0] rel);
      logic [31:0] slot;
      slot = rel - 32'd12;
      if (rel == 32'd3) begin
         if (shift_q != acsv_pkg::TAG_BTAF) note_fail(acsv_pkg::FAIL_FAT_TAG);
      end else if (rel == 32'd7) begin
         fat_sz_q = shift_q;
         if (fat_sz_q < 32'd12 || {32'd0, fat_sz_q} > room_left(64'd16))
            note_fail(acsv_pkg::FAIL_FAT_SIZE);
      end else if (rel == 32'd9) begin
         members_q = shift_q[31:16];
         if ({16'd0, members_q} > ((fat_sz_q - 32'd12) >> 3))
            note_fail(acsv_pkg::FAIL_FAT_SIZE);
         else if (room_left(64'd16 + {32'd0, fat_sz_q}) < 64'd8)
            note_fail(acsv_pkg::FAIL_FNT_TAG);
      end else if (rel >= 32'd12 && (slot >> 3) < {16'd0, members_q}) begin
         if (slot[2:0] == 3'd3) begin
            ent_start_q = shift_q;
         end else if (slot[2:0] == 3'd7) begin
            if (ent_start_q > shift_q) begin
               note_fail(acsv_pkg::FAIL_ENTRY);
               return;
            end
            if (shift_q > max_end_q) max_end_q = shift_q;
         end
      end
      if (phase_q == acsv_pkg::PH_FAT && rel >= 32'd11 && rel == fat_sz_q - 32'd1) begin
         phase_q = acsv_pkg::PH_NAME;
         blk_start_q = 32'd16 + fat_sz_q;
      end
   endfunction

   function automatic void parse_name(input logic [31:0] rel);
      if (rel == 32'd3) begin
         if (shift_q != acsv_pkg::TAG_BTNF) note_fail(acsv_pkg::FAIL_FNT_TAG);
      end else if (rel == 32'd7) begin
         blk_sz_q = shift_q;
         if (blk_sz_q < 32'd8 || {32'd0, blk_sz_q} > room_left({32'd0, blk_start_q}))
            note_fail(acsv_pkg::FAIL_FNT_SIZE);
         else if (room_left({32'd0, blk_start_q} + {32'd0, blk_sz_q}) < 64'd8)
            note_fail(acsv_pkg::FAIL_GMIF_TAG);
      end
      if (phase_q == acsv_pkg::PH_NAME && rel >= 32'd7 && rel == blk_sz_q - 32'd1) begin
         phase_q = acsv_pkg::PH_FILE;
         blk_start_q = blk_start_q + blk_sz_q;
      end
   endfunction

   function automatic void parse_file(input logic [31:0] rel);
      if (rel == 32'd3) begin
         if (shift_q != acsv_pkg::TAG_GMIF) note_fail(acsv_pkg::FAIL_GMIF_TAG);
      end else if (rel == 32'd7) begin
         blk_sz_q = shift_q;
         if (blk_sz_q < 32'd8 || {32'd0, blk_sz_q} > room_left({32'd0, blk_start_q})
             || {32'd0, blk_start_q} + {32'd0, blk_sz_q} != {32'd0, decl_q})
            note_fail(acsv_pkg::FAIL_GMIF_SIZE);
         else if (max_end_q > blk_sz_q - 32'd8)
            note_fail(acsv_pkg::FAIL_ENTRY);
         else
            phase_q = acsv_pkg::PH_DATA;
      end
   endfunction

   // advance the model by one accepted byte; queue a verdict on the last one
   function automatic void track_byte(input logic [7:0] b, input logic lst);
      logic [31:0] pos;
      logic [3:0]  code;
      verdict_type v;
      pos = pos_q;
      if (pos_q == 32'hFFFF_FFFF) over_q = 1'b1;
      else pos_q = pos_q + 32'd1;
      shift_q = {b, shift_q[31:8]};
      if (!over_q) begin
         case (phase_q)
            acsv_pkg::PH_HDR:  parse_header(pos);
            acsv_pkg::PH_FAT:  parse_fat(pos - blk_start_q);
            acsv_pkg::PH_NAME: parse_name(pos - blk_start_q);
            acsv_pkg::PH_FILE: parse_file(pos - blk_start_q);
            default: ;
         endcase
      end
      if (!lst) return;
      code = err_q;
      // a wrong declared size outranks anything found after the size field
      if (code == acsv_pkg::FAIL_NONE || code > acsv_pkg::FAIL_VERSION) begin
         if ((over_q || pos_q >= 32'd12) && (over_q || decl_q != pos_q))
            code = acsv_pkg::FAIL_SIZE;
         else if (code == acsv_pkg::FAIL_NONE && phase_q != acsv_pkg::PH_DATA)
            code = acsv_pkg::FAIL_TRUNC;
      end
      v.ok = (code == acsv_pkg::FAIL_NONE);
      v.code = code;
      v.members = v.ok ? members_q : 16'd0;
      v.offset = v.ok ? blk_start_q + 32'd8 : 32'd0;
      v.count = pos_q;
      verdict_q.push_back(v);
      clear_parser();
   endfunction

   // ---------------- archive builder ----------------

   function automatic void put_bytes(ref logic [7:0] img[$], input logic [31:0] val,
                                     input int len);
      for (int i = 0; i < len; i++) img.push_back(val[8*i +: 8]);
   endfunction

   function automatic void set_bytes(ref logic [7:0] img[$], input int at,
                                     input logic [31:0] val, input int len);
      for (int i = 0; i < len; i++) img[at + i] = val[8*i +: 8];
   endfunction

   function automatic void flip_byte(ref logic [7:0] img[$], input int at);
      img[at] = img[at] ^ 8'($urandom_range(1, 255));
   endfunction

   task automatic make_archive(input int members, input int fat_pad, input int name_body,
                               input int file_body, input mutation_type mut);
      logic [7:0]    img[$];
      logic [31:0]   e_lo, e_hi;
      int            fat_size, fnt_at, gmif_at, total, e_at, cut;
      byte_beat_type beat;
      if ((mut == MUT_ENTRY_ORDER || mut == MUT_ENTRY_END) && members == 0) members = 1;
      fat_size = 12 + 8 * members + fat_pad;
      fnt_at = 16 + fat_size;
      gmif_at = fnt_at + 8 + name_body;
      total = gmif_at + 8 + file_body;
      put_bytes(img, acsv_pkg::TAG_NARC, 4);
      put_bytes(img, {16'd0, acsv_pkg::BYTE_ORDER}, 2);
      put_bytes(img, {16'd0, acsv_pkg::VERSION}, 2);
      put_bytes(img, total, 4);
      put_bytes(img, {16'd0, acsv_pkg::HEADER_LEN}, 2);
      put_bytes(img, {16'd0, acsv_pkg::BLOCK_COUNT}, 2);
      put_bytes(img, acsv_pkg::TAG_BTAF, 4);
      put_bytes(img, fat_size, 4);
      put_bytes(img, members, 2);
      put_bytes(img, $urandom, 2);
      for (int e = 0; e < members; e++) begin
         e_hi = $urandom_range(0, 3) == 0 ? file_body : $urandom_range(0, file_body);
         e_lo = $urandom_range(0, 3) == 0 ? e_hi : $urandom_range(0, e_hi);
         put_bytes(img, e_lo, 4);
         put_bytes(img, e_hi, 4);
      end
      repeat (fat_pad) img.push_back(8'($urandom));
      put_bytes(img, acsv_pkg::TAG_BTNF, 4);
      put_bytes(img, 8 + name_body, 4);
      repeat (name_body) img.push_back(8'($urandom));
      put_bytes(img, acsv_pkg::TAG_GMIF, 4);
      put_bytes(img, 8 + file_body, 4);
      repeat (file_body) img.push_back(8'($urandom));
      e_at = (members > 0) ? 28 + 8 * $urandom_range(0, members - 1) : 28;
      case (mut)
         MUT_TAG:     flip_byte(img, $urandom_range(0, 3));
         MUT_BOM:     flip_byte(img, $urandom_range(4, 5));
         MUT_VER:     flip_byte(img, $urandom_range(6, 7));
         MUT_SIZE:
            set_bytes(img, 8, $urandom_range(0, 1) ? $urandom
                              : total ^ (32'd1 << $urandom_range(0, 31)), 4);
         MUT_HDRLEN:  flip_byte(img, $urandom_range(12, 13));
         MUT_BLOCKS:  flip_byte(img, $urandom_range(14, 15));
         MUT_FAT_TAG: flip_byte(img, $urandom_range(16, 19));
         MUT_FAT_SIZE:
            case ($urandom_range(0, 3))
               0: set_bytes(img, 20, $urandom_range(0, 11), 4);
               1: set_bytes(img, 20, total, 4);
               2: set_bytes(img, 24, 32'h0000_FFFF, 2);
               default: set_bytes(img, 24, members + 1 + $urandom_range(0, 3), 2);
            endcase
         MUT_FNT_TAG: flip_byte(img, fnt_at + $urandom_range(0, 3));
         MUT_FNT_SIZE:
            set_bytes(img, fnt_at + 4, $urandom_range(0, 1) ? $urandom_range(0, 7)
                                       : total - fnt_at - $urandom_range(0, 7), 4);
         MUT_GMIF_TAG: flip_byte(img, gmif_at + $urandom_range(0, 3));
         MUT_GMIF_SIZE:
            set_bytes(img, gmif_at + 4, $urandom_range(0, 1) ? $urandom_range(0, 7)
                                        : (8 + file_body) ^ (32'd1 << $urandom_range(0, 31)),
                      4);
         MUT_ENTRY_ORDER: begin
            e_hi = $urandom_range(0, file_body);
            set_bytes(img, e_at + 4, e_hi, 4);
            set_bytes(img, e_at, $urandom_range(0, 1) ? e_hi + 32'd1 : 32'hFFFF_FFFF, 4);
         end
         MUT_ENTRY_END:
            set_bytes(img, e_at + 4, $urandom_range(0, 1) ? file_body + 1 + $urandom_range(0, 3)
                                     : 32'hFFFF_FFFF, 4);
         MUT_TRUNC: begin
            cut = $urandom_range(1, img.size() - 1);
            img = img[0:cut-1];
         end
         MUT_EXTEND:  repeat ($urandom_range(1, 6)) img.push_back(8'($urandom));
         MUT_POKE:    flip_byte(img, $urandom_range(0, img.size() - 1));
         MUT_NOISE: begin
            img.delete();
            repeat ($urandom_range(1, 30)) img.push_back(8'($urandom));
         end
         default: ;
      endcase
      foreach (img[i]) begin
         beat.data = img[i];
         beat.last = (i == img.size() - 1);
         pending_q.push_back(beat);
      end
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin
      cycle_n <= cycle_n + 1;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) track_byte(req_tdata, req_tlast);
         hold_off = !quiet && ($urandom_range(99) < 21);
         if (pending_q.size() != 0 && !hold_off) begin
            next_beat = pending_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= next_beat.data;
            req_tlast <= next_beat.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   assign quiet = (cycle_n >= QUIET_FROM && cycle_n < QUIET_TO);

   // ---------------- monitor ----------------

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 21);
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               $error("verdict beat with no archive pending: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = verdict_q.pop_front();
               check_field("archive_ok", 32'(want.ok), 32'(rsp_tdata[0]));
               check_field("fail_code", 32'(want.code), 32'(rsp_tdata[4:1]));
               check_field("member_total", 32'(want.members), 32'(rsp_tdata[20:5]));
               check_field("file_data_offset", want.offset, rsp_tdata[52:21]);
               check_field("archive_bytes", want.count, rsp_tdata[84:53]);
               check_field("pad", 32'd0, 32'(rsp_tdata[87:85]));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   // ---------------- stimulus and end of run ----------------

   initial begin
      bit           timed_out;
      mutation_type mut;
      clear_parser();
      timed_out = 1'b0;
      // one archive per corruption kind, plus clean ones with full tables
      make_archive(0, 0, 0, 0, MUT_NONE);
      make_archive(3, 0, 1, 9, MUT_NONE);
      for (int m = MUT_TAG; m <= MUT_NOISE; m++)
         make_archive(2, 1, 2, 4, mutation_type'(m));
      while (pending_q.size() < BYTE_TARGET) begin
         mut = ($urandom_range(99) < 45) ? MUT_NONE
               : mutation_type'($urandom_range(MUT_TAG, MUT_NOISE));
         make_archive($urandom_range(0, 9) == 0 ? $urandom_range(4, 8) : $urandom_range(0, 3),
                      $urandom_range(0, 3), $urandom_range(0, 6),
                      $urandom_range(0, 9) == 0 ? $urandom_range(13, 40) : $urandom_range(0, 12),
                      mut);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (pending_q.size() != 0 || req_tvalid || verdict_q.size() != 0) begin
         @(posedge clock);
         if (stall_cycles >= STALL_LIMIT) begin
            timed_out = 1'b1;
            break;
         end
      end
      if (!timed_out) repeat (8) @(posedge clock);
      if (timed_out) begin
         $display("[FAIL] regression broken");
      end else if (mismatches == 0 && verdict_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: archive_container_stream_validator.f
rtl/acsv_pkg.sv
rtl/acsv_parser.sv
rtl/acsv_result.sv
rtl/archive_container_stream_validator.sv
tb/sv/archive_container_stream_validator_tb.sv
